// ===== rtl/mtf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the move-to-front list.
// Depends on nothing; every other file of the block but mtf_ram imports it.
package mtf_pkg;

    // Number of keys the list can hold.
    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COST_W   = 7;
    localparam int TOTAL_W  = 32;
    localparam int SAT_W    = (CNT_W > COST_W) ? CNT_W : COST_W;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    // Operation codes.
    localparam logic [1:0] ACT_ACCESS = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [KEY_W-1:0] key;
    } mtf_in_t;

    typedef struct packed {
        logic [COST_W-1:0]  cost;
        logic [1:0]         status;
        logic [TOTAL_W-1:0] total_cost;
    } mtf_out_t;

    // Result of one operation before the running total is applied.
    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [1:0]        status;
    } mtf_res_t;

    // Clamp a position count to the width of the cost field.
    function automatic logic [COST_W-1:0] sat_cost(input logic [CNT_W-1:0] v);
        logic [SAT_W-1:0] w;
        w = SAT_W'(v);
        if (w > SAT_W'(COST_MAX))
            return COST_MAX;
        else
            return COST_W'(w);
    endfunction

endpackage

// ===== rtl/mtf_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with one write and one registered read port.
// Generic; used as the key store of the move-to-front list.
module mtf_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/mtf_seq.sv =====
`timescale 1ns / 1ps
// Sequencer of the move-to-front list: search, shift and append in the key RAM.
// Depends on mtf_pkg; drives mtf_ram and hands one result at a time to mtf_out.
module mtf_seq
    import mtf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mtf_in_t          in_data,
    output logic             res_valid,
    input  logic             res_ready,
    output mtf_res_t         res,
    output logic             ram_we,
    output logic [IDX_W-1:0] ram_waddr,
    output logic [KEY_W-1:0] ram_wdata,
    output logic [IDX_W-1:0] ram_raddr,
    input  logic [KEY_W-1:0] ram_rdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_MOVE   = 3'd2;
    localparam logic [2:0] S_FRONT  = 3'd3;
    localparam logic [2:0] S_CLOSE  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]        state_reg,  state_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [1:0]        act_reg,    act_next;
    logic [KEY_W-1:0]  key_reg,    key_next;
    logic [IDX_W-1:0]  idx_reg,    idx_next;
    logic [COST_W-1:0] cost_reg,   cost_next;
    logic [1:0]        status_reg, status_next;

    logic             hit;
    logic             last;
    logic [CNT_W-1:0] idx_plus1;

    // The entry at idx_reg is on the RAM read data during a search.
    assign idx_plus1 = CNT_W'(idx_reg) + CNT_W'(1);
    assign hit       = (ram_rdata == key_reg);
    assign last      = (idx_plus1 == count_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.cost   = cost_reg;
    assign res.status = status_reg;

    // Next-state and RAM control.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        act_next    = act_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        cost_next   = cost_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = key_reg;
        ram_raddr   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next    = in_data.action;
                    key_next    = in_data.key;
                    idx_next    = '0;
                    cost_next   = '0;
                    status_next = ST_DONE;
                    state_next  = S_DONE;
                    case (in_data.action)
                        ACT_INSERT:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[IDX_W-1:0];
                                ram_wdata  = in_data.key;
                                count_next = count_reg + CNT_W'(1);
                                cost_next  = sat_cost(count_reg + CNT_W'(1));
                            end
                        end
                        ACT_ACCESS, ACT_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                ram_raddr  = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Walk the list from the front, one entry a cycle.
            S_SEARCH:
            begin
                if (hit)
                begin
                    cost_next   = sat_cost(idx_plus1);
                    status_next = ST_DONE;
                    if (act_reg == ACT_ACCESS)
                    begin
                        if (idx_reg == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ram_raddr  = idx_reg - IDX_W'(1);
                            state_next = S_MOVE;
                        end
                    end
                    else if (last)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ram_raddr  = idx_reg + IDX_W'(1);
                        state_next = S_CLOSE;
                    end
                end
                else if (last)
                begin
                    cost_next   = sat_cost(count_reg);
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    ram_raddr = idx_reg + IDX_W'(1);
                    idx_next  = idx_reg + IDX_W'(1);
                end
            end

            // Shift the entries in front of the hit back by one.
            S_MOVE:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                if (idx_reg == IDX_W'(1))
                begin
                    state_next = S_FRONT;
                end
                else
                begin
                    ram_raddr = idx_reg - IDX_W'(2);
                    idx_next  = idx_reg - IDX_W'(1);
                end
            end

            // The hit key equals the search key, so write that at the front.
            S_FRONT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = key_reg;
                state_next = S_DONE;
            end

            // Close the gap left by a removed key.
            S_CLOSE:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                if (idx_plus1 + CNT_W'(1) == count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr = idx_reg + IDX_W'(2);
                    idx_next  = idx_reg + IDX_W'(1);
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        cost_reg   <= cost_next;
        status_reg <= status_next;
    end

endmodule

// ===== rtl/mtf_out.sv =====
`timescale 1ns / 1ps
// Running cost total and output register of the move-to-front list.
// Depends on mtf_pkg; takes results from mtf_seq.
module mtf_out
    import mtf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     res_valid,
    output logic     res_ready,
    input  mtf_res_t res,
    output logic     out_valid,
    input  logic     out_ready,
    output mtf_out_t out_data
);

    logic               out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0] total_reg,     total_next;
    mtf_out_t           out_reg;
    logic [TOTAL_W:0]   sum;
    logic               take;

    assign res_ready = !out_valid_reg || out_ready;
    assign take      = res_valid && res_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Saturating add of this item's cost, and the next value of the output valid flag.
    always_comb
    begin
        sum = {1'b0, total_reg} + (TOTAL_W + 1)'(res.cost);
        if (sum[TOTAL_W])
            total_next = '1;
        else
            total_next = sum[TOTAL_W-1:0];

        if (take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                total_reg <= total_next;
            end
        end
    end

    // Result item register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg.cost       <= res.cost;
            out_reg.status     <= res.status;
            out_reg.total_cost <= total_next;
        end
    end

endmodule

// ===== rtl/move_to_front_list.sv =====
`timescale 1ns / 1ps
// Top level of the move-to-front list: key RAM, sequencer and output stage.
// Depends on mtf_pkg, mtf_ram, mtf_seq and mtf_out.
//
// Usage: each input item on in_valid/in_ready/in_data carries an action
// (access, insert or remove) and a 32-bit key. Each accepted item yields
// exactly one result item on out_valid/out_ready/out_data with the cost,
// a status and the running saturating cost total.
// The keys live in a 64-entry RAM with one write and one read port. An
// access or remove scans the RAM from the front, one entry a cycle, and
// then shifts the entries over, one per cycle, through the same ports.
// One item is worked at a time; in_ready rises again with the clock edge that
// loads the result into the output register. Reset empties the list and clears
// the cost total; the RAM needs no clearing pass. A stalled receiver holds the
// result in the output register while the next item is already worked.
module move_to_front_list
    import mtf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  mtf_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output mtf_out_t out_data
);

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [KEY_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [KEY_W-1:0] ram_rdata;
    logic             res_valid;
    logic             res_ready;
    mtf_res_t         res;

    mtf_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mtf_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    mtf_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/mtf_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the move-to-front list, bound to the top level.
// Depends on mtf_pkg.
module mtf_checker
    import mtf_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input mtf_in_t  in_data,
    input logic     out_valid,
    input logic     out_ready,
    input mtf_out_t out_data
);

    logic [TOTAL_W-1:0] last_total_reg;

    // Total of the most recently delivered result item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_total_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            last_total_reg <= out_data.total_cost;
        end
    end

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    // The running total never goes down.
    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.total_cost >= last_total_reg)
        else $error("cost total decreased");

    // A rejected insert costs nothing.
    a_full_cost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_FULL |-> out_data.cost == '0)
        else $error("full insert charged a cost");

    // Only one item is worked at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while busy");

    // Status is never the unused code.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status == ST_DONE || out_data.status == ST_NOT_FOUND
                      || out_data.status == ST_FULL)
        else $error("invalid status code");

endmodule

bind move_to_front_list mtf_checker u_mtf_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the move-to-front key list (move_to_front_list).
// Depends on mtf_pkg and the block's RTL; a shadow list predicts each result.
module testbench;
    import mtf_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam int POOL_SIZE = 20;

    // Traffic shapes for the phases of the run.
    localparam int MODE_STEADY   = 0;
    localparam int MODE_SEND_GAP = 1;
    localparam int MODE_RECV_GAP = 2;
    localparam int MODE_BOTH_GAP = 3;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    mtf_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    mtf_out_t out_data;

    mtf_in_t  pending_ops[$];
    mtf_out_t expected_results[$];

    // Shadow copy of the list held by the block.
    logic [KEY_W-1:0]   list_keys[CAPACITY];
    int                 list_len = 0;
    logic [TOTAL_W-1:0] running_total = '0;

    logic [KEY_W-1:0] key_pool[POOL_SIZE];
    int   idle_mode   = MODE_STEADY;
    int   hold_cycles = 0;
    int   mismatches  = 0;
    logic in_fire     = 1'b0;

    move_to_front_list u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Apply one operation to the shadow list and return the result it yields.
    function automatic mtf_out_t apply_list_op(mtf_in_t op);
        mtf_out_t             res;
        int                   pos;
        int                   cost;
        logic [KEY_W-1:0]     hit;
        logic [TOTAL_W:0]     sum;
        res        = '0;
        res.status = ST_DONE;
        cost       = 0;
        pos        = list_len;
        if (op.action == ACT_ACCESS || op.action == ACT_REMOVE)
        begin
            // Scan from the tail so that the first match from the front wins.
            for (int i = list_len - 1; i >= 0; i--)
            begin
                if (list_keys[i] == op.key)
                    pos = i;
            end
            if (pos == list_len)
            begin
                cost       = list_len;
                res.status = ST_NOT_FOUND;
            end
            else
            begin
                cost = pos + 1;
                if (op.action == ACT_ACCESS)
                begin
                    hit = list_keys[pos];
                    for (int i = pos; i > 0; i--)
                        list_keys[i] = list_keys[i - 1];
                    list_keys[0] = hit;
                end
                else
                begin
                    for (int i = pos; i < list_len - 1; i++)
                        list_keys[i] = list_keys[i + 1];
                    list_len--;
                end
            end
        end
        else if (op.action == ACT_INSERT)
        begin
            if (list_len >= CAPACITY)
                res.status = ST_FULL;
            else
            begin
                cost                = list_len + 1;
                list_keys[list_len] = op.key;
                list_len++;
            end
        end
        // Costs wider than the field clamp before they join the total.
        if (cost > int'(COST_MAX))
            cost = int'(COST_MAX);
        sum = {1'b0, running_total} + (TOTAL_W + 1)'(cost);
        running_total  = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        res.cost       = COST_W'(cost);
        res.total_cost = running_total;
        return res;
    endfunction

    // Input side: move to the next item once the current one is taken.
    always @(negedge clk)
    begin
        if (!in_valid || in_fire)
        begin
            if (pending_ops.size() != 0 &&
                !((idle_mode == MODE_SEND_GAP && $urandom_range(99) < 58) ||
                  (idle_mode == MODE_BOTH_GAP && $urandom_range(99) < 8)))
            begin
                in_valid <= 1'b1;
                in_data  <= pending_ops.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output side: random stalls, plus a long hold-off on request.
    always @(negedge clk)
    begin
        out_ready <= (hold_cycles == 0) &&
                     !((idle_mode == MODE_RECV_GAP && $urandom_range(99) < 58) ||
                       (idle_mode == MODE_BOTH_GAP && $urandom_range(99) < 8));
    end

    // Count down the receiver hold-off.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // Predict on each accepted item and check each accepted result.
    always @(posedge clk)
    begin
        mtf_out_t want;
        in_fire <= in_valid && in_ready && rst_n;
        if (rst_n && in_valid && in_ready)
            expected_results.push_back(apply_list_op(in_data));
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result item with no item pending: cost %0d status %0d total %0d",
                       out_data.cost, out_data.status, out_data.total_cost);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.cost !== want.cost)
                begin
                    $error("cost: expected %0d, actual %0d", want.cost, out_data.cost);
                    mismatches++;
                end
                if (out_data.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, out_data.status);
                    mismatches++;
                end
                if (out_data.total_cost !== want.total_cost)
                begin
                    $error("total_cost: expected %0d, actual %0d",
                           want.total_cost, out_data.total_cost);
                    mismatches++;
                end
            end
        end
    end

    task automatic push_op(input logic [1:0] act, input logic [KEY_W-1:0] k);
        mtf_in_t item;
        item.action = act;
        item.key    = k;
        pending_ops.push_back(item);
    endtask

    // Keys mostly come from a small pool so that searches hit.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 90)
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // One segment of random items with the given percentages of insert
    // and remove; the rest are accesses, with a little noise mixed in.
    task automatic push_segment(input int n, input int ins_pct, input int rem_pct);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < ins_pct)
                push_op(ACT_INSERT, pick_key());
            else if (r < ins_pct + rem_pct)
                push_op(ACT_REMOVE, pick_key());
            else if ($urandom_range(99) < 4)
                push_op(ACT_UNUSED, $urandom);
            else
                push_op(ACT_ACCESS, pick_key());
        end
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed items: empty list, extreme keys, duplicates, misses.
        push_op(ACT_ACCESS, 32'h0000_0005);
        push_op(ACT_REMOVE, 32'h0000_0005);
        push_op(ACT_INSERT, 32'h8000_0000);
        push_op(ACT_INSERT, 32'h7FFF_FFFF);
        push_op(ACT_INSERT, 32'h0000_0000);
        push_op(ACT_INSERT, 32'hFFFF_FFFF);
        push_op(ACT_INSERT, 32'h7FFF_FFFF);
        push_op(ACT_ACCESS, 32'hFFFF_FFFF);
        push_op(ACT_ACCESS, 32'hFFFF_FFFF);
        push_op(ACT_ACCESS, 32'h7FFF_FFFF);
        push_op(ACT_REMOVE, 32'h7FFF_FFFF);
        push_op(ACT_ACCESS, 32'h0000_3039);
        push_op(ACT_REMOVE, 32'h0000_3039);
        push_op(ACT_UNUSED, 32'hFFFF_FFFF);
        push_op(ACT_REMOVE, 32'h0000_0000);
        push_op(ACT_REMOVE, 32'h8000_0000);
        push_op(ACT_REMOVE, 32'h7FFF_FFFF);
        push_op(ACT_REMOVE, 32'hFFFF_FFFF);
        push_op(ACT_ACCESS, 32'h0000_0000);
        push_op(ACT_UNUSED, 32'h0000_0000);
        wait_drained();

        // Random phases: fill past capacity, churn, then drain.
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_mode = ph;
            for (int i = 0; i < POOL_SIZE; i++)
                key_pool[i] = $urandom;
            push_segment(80, 92, 0);
            push_segment(60, 10, 25);
            push_segment(50, 5, 70);
            // Hold the receiver off while the sender keeps offering.
            if (ph == MODE_STEADY)
            begin
                @(posedge clk);
                hold_cycles = 400;
            end
            wait_drained();
        end

        repeat (150) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected result items never arrived", expected_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("move_to_front_list verification clean");
        else
            $display("move_to_front_list verification failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #10_000_000;
        $display("move_to_front_list verification failed");
        $finish;
    end

endmodule
